### hw/rtl/pldw_pkg.sv
// ----------------------------------------------------------------------------
// pldw_pkg: shared types and constants for the pin level wait debouncer
// Phase encoding, wait mode codes, widths and the pin sampling helper.
// ----------------------------------------------------------------------------
package pldw_pkg;

  localparam int PIN_COUNT = 32;
  localparam int PINS_W    = 32;
  localparam int MODE_W    = 3;
  localparam int SEL_W     = 5;
  localparam int CNT_W     = 16;

  localparam logic [CNT_W-1:0] SETTLE_RESET = 16'd20;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEEK   = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  // low two mode bits: what to wait for; mode bit 2: skip settling
  typedef enum logic [1:0] {
    BASE_HIGH   = 2'd0,
    BASE_LOW    = 2'd1,
    BASE_CHANGE = 2'd2,
    BASE_READ   = 2'd3
  } wait_base_t;

  localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INVALID = 3'd7;

  // pins at or above PIN_COUNT read as low
  function automatic logic sample_pin(logic [PINS_W-1:0] pins, logic [SEL_W-1:0] idx);
    logic bit_val;
    bit_val = 1'b0;
    if (int'(idx) < PIN_COUNT) begin
      bit_val = pins[idx];
    end
    return bit_val;
  endfunction

endpackage

### hw/rtl/pldw_if.sv
// ----------------------------------------------------------------------------
// pldw_if: item channels of the pin level wait debouncer
// Input tick channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pldw_in_if;
  import pldw_pkg::*;

  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] pin_levels;
  logic              start_req;
  logic [MODE_W-1:0] mode;
  logic [SEL_W-1:0]  pin_select;
  logic              abort_request;

  modport source (output valid, pin_levels, start_req, mode, pin_select, abort_request,
                  input ready);
  modport sink   (input valid, pin_levels, start_req, mode, pin_select, abort_request,
                  output ready);
endinterface

interface pldw_out_if;
  logic valid;
  logic ready;
  logic level;
  logic aborted;

  modport source (output valid, level, aborted, input ready);
  modport sink   (input valid, level, aborted, output ready);
endinterface

### hw/rtl/pin_level_wait_debouncer_unit.sv
// ----------------------------------------------------------------------------
// pin_level_wait_debouncer_unit: debounced wait on one pin with settle timer
// Seeks a target level on a selected pin and reports once it has held.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one item per timer tick: sampled pin bus, start request with
//             mode and pin select, abort request.
//   out_ch  : one item when a wait completes (settled level) or is aborted
//             (level of the watched pin on the abort tick, aborted = 1).
//   cfg_we / cfg_wdata : settle_ticks, written while the block is idle.
// Path: an item accepted on in_ch passes through the input register, then the
//   decision logic into the result register, which drives out_ch.
// Throughput: one item per cycle while out_ch is not stalled; the settle counter
//   and its compare sit in a single stage between the input and result registers.
// Stall: while a result waits on out_ch the held input item stays parked;
//   in_ch.ready stays high as long as the input register is empty or the
//   result register is free to load.
// Reset: phase idle, mode/pin/target/count cleared, settle_ticks = 20,
//   both registers empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pin_level_wait_debouncer_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  pldw_in_if.sink                 in_ch,
  pldw_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [pldw_pkg::CNT_W-1:0] cfg_wdata
);
  import pldw_pkg::*;

  // config
  logic [CNT_W-1:0]  settle_ticks_r;

  // input register
  logic              in_vld_r;
  logic [PINS_W-1:0] pins_r;
  logic              start_r;
  logic [MODE_W-1:0] mode_in_r;
  logic [SEL_W-1:0]  sel_r;
  logic              abort_r;

  // wait state
  phase_t            phase_r,  phase_nxt;
  logic [MODE_W-1:0] amode_r,  amode_nxt;
  logic [SEL_W-1:0]  wpin_r,   wpin_nxt;
  logic              target_r, target_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;

  // result register
  logic              out_vld_r;
  logic              out_level_r;
  logic              out_aborted_r;

  logic              advance;
  logic              process;

  // decoded view of the held item
  logic              start_ok;
  wait_base_t        base;
  logic              skip_eval;
  logic              lvl_sel;
  logic              lvl;
  logic              lvl_abort;
  phase_t            eff_phase;
  logic [MODE_W-1:0] eff_mode;
  logic [SEL_W-1:0]  eff_pin;
  logic              eff_target;
  logic [CNT_W-1:0]  count_inc;
  logic              zero_settle;

  logic              res_valid;
  logic              res_level;
  logic              res_aborted;

  // handshake: result register frees when empty or taken
  assign advance     = !out_vld_r || out_ch.ready;
  assign process     = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  assign out_ch.valid   = out_vld_r;
  assign out_ch.level   = out_level_r;
  assign out_ch.aborted = out_aborted_r;

  // abort wins over start; mode 7 starts are dropped
  assign start_ok    = start_r && !abort_r && (mode_in_r != MODE_INVALID);
  assign base        = wait_base_t'(mode_in_r[1:0]);
  assign skip_eval   = start_ok && (base == BASE_CHANGE || base == BASE_READ);
  assign zero_settle = (settle_ticks_r == '0);

  assign lvl_sel   = sample_pin(pins_r, sel_r);
  assign lvl_abort = sample_pin(pins_r, wpin_r);

  always_comb begin
    eff_phase  = phase_r;
    eff_mode   = amode_r;
    eff_pin    = wpin_r;
    eff_target = target_r;
    if (start_ok) begin
      eff_mode = mode_in_r;
      eff_pin  = sel_r;
      case (base)
        BASE_HIGH: begin
          eff_target = 1'b1;
          eff_phase  = PH_SEEK;
        end
        BASE_LOW: begin
          eff_target = 1'b0;
          eff_phase  = PH_SEEK;
        end
        BASE_CHANGE: begin
          eff_target = !lvl_sel;
          eff_phase  = PH_SEEK;
        end
        default: begin
          eff_target = lvl_sel;
          eff_phase  = PH_SETTLE;
        end
      endcase
    end
  end

  assign lvl       = sample_pin(pins_r, eff_pin);
  assign count_inc = (count_r == '1) ? count_r : count_r + CNT_W'(1);

  // result decision
  always_comb begin
    res_valid   = 1'b0;
    res_level   = eff_target;
    res_aborted = 1'b0;
    if (abort_r) begin
      res_valid   = (phase_r != PH_IDLE);
      res_level   = lvl_abort;
      res_aborted = 1'b1;
    end else if (start_ok && base == BASE_READ) begin
      res_valid = zero_settle;
      res_level = lvl_sel;
    end else if (!skip_eval) begin
      case (eff_phase)
        PH_SEEK:   res_valid = (lvl == eff_target) && (eff_mode[2] || zero_settle);
        PH_SETTLE: res_valid = (lvl == eff_target) && (count_inc >= settle_ticks_r);
        default:   res_valid = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    amode_nxt  = amode_r;
    wpin_nxt   = wpin_r;
    target_nxt = target_r;
    count_nxt  = count_r;
    if (!abort_r) begin
      phase_nxt  = eff_phase;
      amode_nxt  = eff_mode;
      wpin_nxt   = eff_pin;
      target_nxt = eff_target;
      if (start_ok) begin
        count_nxt = '0;
      end
      if (!skip_eval) begin
        case (eff_phase)
          PH_SEEK: begin
            if (lvl == eff_target) begin
              phase_nxt = PH_SETTLE;
              count_nxt = '0;
            end
          end
          PH_SETTLE: begin
            if (lvl != eff_target) begin
              count_nxt = '0;
              if (eff_mode == MODE_READ) begin
                target_nxt = lvl;
              end
            end else begin
              count_nxt = count_inc;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
    // any completion or abort returns to idle
    if (res_valid) begin
      phase_nxt = PH_IDLE;
      count_nxt = '0;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      settle_ticks_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      pins_r    <= in_ch.pin_levels;
      start_r   <= in_ch.start_req;
      mode_in_r <= in_ch.mode;
      sel_r     <= in_ch.pin_select;
      abort_r   <= in_ch.abort_request;
    end
  end

  // wait state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      amode_r  <= '0;
      wpin_r   <= '0;
      target_r <= 1'b0;
      count_r  <= '0;
    end else if (process) begin
      phase_r  <= phase_nxt;
      amode_r  <= amode_nxt;
      wpin_r   <= wpin_nxt;
      target_r <= target_nxt;
      count_r  <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= process && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process && res_valid) begin
      out_level_r   <= res_level;
      out_aborted_r <= res_aborted;
    end
  end

endmodule

### hw/rtl/pldw_checker.sv
// ----------------------------------------------------------------------------
// pldw_checker: port-level checks for the pin level wait debouncer
// Watches the channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pldw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_level,
  input logic out_aborted
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_level) && $stable(out_aborted))
    else $error("result payload changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a fresh result always traces to an item accepted on in_ch
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted item");

endmodule

bind pin_level_wait_debouncer_unit pldw_checker u_pldw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_level   (out_ch.level),
  .out_aborted (out_ch.aborted)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for pin_level_wait_debouncer_unit
// A directed table runs first, then random bursts under several settle
// settings. The random bursts are wait starts followed by bouncing pin
// levels, mixed with noise items. A scoreboard predicts each result item
// and checks it field by field. Both channels idle at random. One long
// receiver hold-off backs up the block, and one wait runs at the largest
// settle count.
// ----------------------------------------------------------------------------
module tb;
  import pldw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_HIGH      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOW       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHANGE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIGH_NS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOW_NS    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CHANGE_NS = 3'd6;

  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              start;
    logic [MODE_W-1:0] mode;
    logic [SEL_W-1:0]  sel;
    logic              abort;
  } tick_t;

  typedef struct packed {
    logic level;
    logic aborted;
  } wait_result_t;

  // typed = 1: the expected result is written in the row itself
  typedef struct packed {
    tick_t        t;
    bit           typed;
    bit           exp_has;
    wait_result_t exp;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  // directed rows; the settle count is still at its reset value here
  dir_row_t dir_rows [DIR_ROWS] = '{
    // abort while idle: nothing comes out
    '{'{32'h0000_0000, 1'b0, MODE_HIGH,      5'd0,  1'b1}, 1'b1, 1'b0, 2'b00},
    // no-settle waits already at their target complete on the start item
    '{'{32'h0000_0001, 1'b1, MODE_HIGH_NS,   5'd0,  1'b0}, 1'b1, 1'b1, 2'b10},
    '{'{32'h0000_0000, 1'b1, MODE_LOW_NS,    5'd31, 1'b0}, 1'b1, 1'b1, 2'b00},
    '{'{32'h8000_0000, 1'b1, MODE_HIGH_NS,   5'd31, 1'b0}, 1'b1, 1'b1, 2'b10},
    // change wait: start item only sets the reference
    '{'{32'hFFFF_FFFF, 1'b1, MODE_CHANGE_NS, 5'd5,  1'b0}, 1'b1, 1'b0, 2'b00},
    '{'{32'h0000_0000, 1'b0, MODE_HIGH,      5'd0,  1'b0}, 1'b1, 1'b1, 2'b00},
    // abort reports the watched pin as sampled on the abort item
    '{'{32'h0000_0000, 1'b1, MODE_HIGH,      5'd3,  1'b0}, 1'b1, 1'b0, 2'b00},
    '{'{32'hFFFF_FFFF, 1'b0, MODE_HIGH,      5'd0,  1'b1}, 1'b1, 1'b1, 2'b11},
    // settle restarts on a wrong level; mode 7 start is ignored
    '{'{32'h0000_0000, 1'b1, MODE_LOW,       5'd7,  1'b0}, 1'b0, 1'b0, 2'b00},
    '{'{32'h0000_0000, 1'b1, MODE_INVALID,   5'd0,  1'b0}, 1'b0, 1'b0, 2'b00},
    '{'{32'h0000_0080, 1'b0, MODE_HIGH,      5'd0,  1'b0}, 1'b0, 1'b0, 2'b00},
    // start while busy drops the running wait
    '{'{32'h0000_0080, 1'b1, MODE_READ,      5'd7,  1'b0}, 1'b0, 1'b0, 2'b00},
    '{'{32'h0000_0000, 1'b1, MODE_CHANGE,    5'd0,  1'b0}, 1'b0, 1'b0, 2'b00},
    '{'{32'h0000_0001, 1'b0, MODE_HIGH,      5'd0,  1'b0}, 1'b0, 1'b0, 2'b00},
    '{'{32'hFFFF_FFFE, 1'b0, MODE_HIGH,      5'd0,  1'b1}, 1'b1, 1'b1, 2'b01},
    // abort wins over a start on the same item
    '{'{32'h0000_0002, 1'b1, MODE_HIGH_NS,   5'd1,  1'b1}, 1'b1, 1'b0, 2'b00},
    '{'{32'h0000_0002, 1'b0, MODE_HIGH,      5'd0,  1'b0}, 1'b1, 1'b0, 2'b00},
    '{'{32'h0000_0000, 1'b1, MODE_INVALID,   5'd31, 1'b1}, 1'b1, 1'b0, 2'b00}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pldw_in_if  in_ch();
  pldw_out_if out_ch();

  pin_level_wait_debouncer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted wait state
  phase_t            wt_phase;
  logic [MODE_W-1:0] wt_mode;
  logic [SEL_W-1:0]  wt_pin;
  logic              wt_target;
  logic [CNT_W-1:0]  wt_count;
  logic [CNT_W-1:0]  wt_settle;

  wait_result_t pending_results [$];
  int           mismatches = 0;
  bit           idle_on = 1'b1;
  bit           hold_off_req = 1'b0;

  function automatic logic pin_at(logic [PINS_W-1:0] pins, logic [SEL_W-1:0] idx);
    return (int'(idx) < PIN_COUNT) ? pins[idx] : 1'b0;
  endfunction

  function automatic bit close_wait(input logic lvl, input logic ab, output wait_result_t r);
    r.level   = lvl;
    r.aborted = ab;
    wt_phase  = PH_IDLE;
    wt_count  = '0;
    return 1'b1;
  endfunction

  // advances the wait state by one tick; returns 1 when a result is due
  function automatic bit predict_tick(input tick_t t, output wait_result_t r);
    logic       lv;
    wait_base_t base;
    r = '0;
    if (t.abort) begin
      if (wt_phase != PH_IDLE) return close_wait(pin_at(t.pins, wt_pin), 1'b1, r);
      return 1'b0;
    end
    if (t.start && t.mode != MODE_INVALID) begin
      base     = wait_base_t'(t.mode[1:0]);
      wt_mode  = t.mode;
      wt_pin   = t.sel;
      wt_count = '0;
      lv       = pin_at(t.pins, t.sel);
      case (base)
        BASE_HIGH: begin
          wt_target = 1'b1;
          wt_phase  = PH_SEEK;
        end
        BASE_LOW: begin
          wt_target = 1'b0;
          wt_phase  = PH_SEEK;
        end
        BASE_CHANGE: begin
          wt_target = ~lv;
          wt_phase  = PH_SEEK;
          return 1'b0;
        end
        default: begin
          wt_target = lv;
          if (wt_settle == '0) return close_wait(lv, 1'b0, r);
          wt_phase = PH_SETTLE;
          return 1'b0;
        end
      endcase
    end
    lv = pin_at(t.pins, wt_pin);
    case (wt_phase)
      PH_SEEK: begin
        if (lv != wt_target) return 1'b0;
        if (wt_mode[2] || wt_settle == '0) return close_wait(wt_target, 1'b0, r);
        wt_phase = PH_SETTLE;
        wt_count = '0;
      end
      PH_SETTLE: begin
        if (lv != wt_target) begin
          wt_count = '0;
          if (wt_mode == MODE_READ) wt_target = lv;
          return 1'b0;
        end
        if (wt_count != '1) wt_count = wt_count + CNT_W'(1);
        if (wt_count >= wt_settle) return close_wait(wt_target, 1'b0, r);
      end
      default: wt_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // offers one item, waits for it to be taken, then maybe idles a while
  task automatic drive_tick(input tick_t t, input bit typed = 1'b0,
                            input bit exp_has = 1'b0, input wait_result_t exp = '0);
    wait_result_t r;
    bit           has;
    int           g;
    in_ch.valid         <= 1'b1;
    in_ch.pin_levels    <= t.pins;
    in_ch.start_req     <= t.start;
    in_ch.mode          <= t.mode;
    in_ch.pin_select    <= t.sel;
    in_ch.abort_request <= t.abort;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = predict_tick(t, r);
    if (typed) begin
      has = exp_has;
      r   = exp;
    end
    if (has) pending_results.push_back(r);
    if (idle_on && $urandom_range(0, 9) < 3) begin
      in_ch.valid <= 1'b0;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (g) @(posedge clk);
    end
  endtask

  // settle count is only changed with nothing in flight
  task automatic write_settle(input logic [CNT_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wt_settle = v;
  endtask

  // one wait start followed by a bouncing then mostly steady pin, or noise
  task automatic run_burst(inout int sent);
    tick_t            t;
    logic             lvl;
    logic [SEL_W-1:0] pin;
    int               len;
    int               cap;
    int               bounce;
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        t.pins  = $urandom;
        t.start = ($urandom_range(0, 3) == 0);
        t.mode  = MODE_W'($urandom_range(0, 7));
        t.sel   = SEL_W'($urandom_range(0, 31));
        t.abort = ($urandom_range(0, 5) == 0);
        drive_tick(t);
        sent++;
      end
      return;
    end
    pin    = SEL_W'($urandom_range(0, 31));
    lvl    = 1'($urandom_range(0, 1));
    cap    = (wt_settle > 30) ? 30 : int'(wt_settle);
    len    = $urandom_range(1, cap + 12);
    bounce = $urandom_range(0, 4);
    t.mode = ($urandom_range(0, 15) == 0) ? MODE_INVALID : 3'($urandom_range(0, 6));
    t.sel  = pin;
    t.start = 1'b1;
    t.abort = 1'b0;
    t.pins  = $urandom;
    t.pins[pin] = lvl;
    drive_tick(t);
    sent++;
    for (int i = 0; i < len; i++) begin
      if (bounce > 0) begin
        if ($urandom_range(0, 2) == 0) lvl = ~lvl;
        bounce--;
      end else if ($urandom_range(0, 39) == 0) begin
        lvl = ~lvl;
      end
      t.pins      = $urandom;
      t.pins[pin] = lvl;
      t.start     = ($urandom_range(0, 59) == 0);
      t.mode      = MODE_W'($urandom_range(0, 7));
      t.sel       = SEL_W'($urandom_range(0, 31));
      t.abort     = ($urandom_range(0, 49) == 0);
      drive_tick(t);
      sent++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random ready, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!idle_on || $urandom_range(0, 9) < 7) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    wait_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item level=%0b aborted=%0b", $time,
                 out_ch.level, out_ch.aborted);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.level !== want.level) begin
          $display("%0t: level expected %0b actual %0b", $time, want.level, out_ch.level);
          mismatches++;
        end
        if (out_ch.aborted !== want.aborted) begin
          $display("%0t: aborted expected %0b actual %0b", $time, want.aborted,
                   out_ch.aborted);
          mismatches++;
        end
      end
    end
  end

  initial begin
    tick_t            t;
    int               sent;
    logic [CNT_W-1:0] nxt;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.pin_levels    <= '0;
    in_ch.start_req     <= 1'b0;
    in_ch.mode          <= '0;
    in_ch.pin_select    <= '0;
    in_ch.abort_request <= 1'b0;
    wt_phase  = PH_IDLE;
    wt_mode   = '0;
    wt_pin    = '0;
    wt_target = 1'b0;
    wt_count  = '0;
    wt_settle = SETTLE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      drive_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].exp_has, dir_rows[i].exp);

    // first phase keeps the reset settle count; later phases rewrite it
    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        case (p)
          1, 8:    nxt = '0;
          2:       nxt = 16'd1;
          3:       nxt = '1;
          4:       nxt = 16'd2;
          6:       nxt = 16'd3;
          default: nxt = CNT_W'($urandom_range(0, 12));
        endcase
        write_settle(nxt);
      end
      idle_on = (p % 4 != 2);
      sent = 0;
      while (sent < 150) run_burst(sent);
    end

    // hold off the result side while no-settle waits keep completing
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) begin
      t.pins     = $urandom;
      t.pins[0]  = 1'b1;
      t.start    = 1'b1;
      t.mode     = MODE_HIGH_NS;
      t.sel      = '0;
      t.abort    = 1'b0;
      drive_tick(t);
    end

    // one wait at the largest settle count, held steady and then aborted
    write_settle('1);
    t.pins     = $urandom;
    t.pins[17] = 1'b1;
    t.start    = 1'b1;
    t.mode     = MODE_HIGH;
    t.sel      = 5'd17;
    t.abort    = 1'b0;
    drive_tick(t);
    t.start = 1'b0;
    repeat (40) begin
      t.pins     = $urandom;
      t.pins[17] = 1'b1;
      t.mode     = MODE_W'($urandom_range(0, 7));
      drive_tick(t);
    end
    t.abort = 1'b1;
    drive_tick(t);
    idle_on = 1'b1;

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
